// ===== design/hip_pkg.sv =====
// Shared types and constants for the handle ID pool.
package hip_pkg;

    localparam int HID_W = 10;
    localparam int OFS_W = 32;
    localparam int SER_W = 32;
    localparam int ST_W  = 2;
    localparam int S_DATA_W = 48;
    localparam int M_DATA_W = 48;

    typedef enum logic [ST_W-1:0] {
        ST_OK            = 2'd0,
        ST_EXHAUSTED     = 2'd1,
        ST_BAD_OFFSET    = 2'd2,
        ST_NOT_ALLOCATED = 2'd3
    } status_t;

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } op_t;

    typedef struct packed {
        logic rd_en;
        logic pop;
        logic push;
    } stk_ctrl_t;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic wr_val;
        logic bump;
    } vmap_ctrl_t;

endpackage

// ===== design/handle_id_pool.sv =====
// Top level of the handle ID pool: request sequencing, serial counter and result register.
//
//  Channel | Direction | tdata (lowest bit first)                | tuser
//  s_      | in        | handle_id[9:0], handle_offset[31:0]     | op
//  m_      | out       | granted_id[9:0], serial[31:0], status   | -
//
// Each transaction first reads both memories, then decides and writes back.
// A new transaction is taken only once the previous one has left the decide step.
// The input is taken while a finished result still waits; the decide cycle stalls until it goes.
// After reset the stack is empty, no ID is valid and the serial counter is zero.
module handle_id_pool
    import hip_pkg::*;
#(
    parameter int ID_BITS = 10
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,  // handle_id, handle_offset
    input  logic                s_tuser,  // op
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata   // granted_id, serial, status
);

    localparam int WIDE = (ID_BITS > HID_W) ? ID_BITS : HID_W;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    state_t             state_reg;
    logic               op_reg;
    logic               in_range_reg;
    logic               ofs_nz_reg;
    logic [ID_BITS-1:0] id_reg;
    logic [SER_W-1:0]   serial_reg;
    logic [SER_W-1:0]   serial_next;
    logic               out_valid_reg;
    logic [HID_W-1:0]   out_id_reg;
    logic [SER_W-1:0]   out_serial_reg;
    status_t            out_status_reg;

    logic               accept;
    logic               can_load;
    logic               load;
    logic [WIDE-1:0]    hid_wide;
    logic               hid_in_range;
    logic [ID_BITS-1:0] hid_id;

    stk_ctrl_t          stk_ctrl;
    vmap_ctrl_t         vmap_ctrl;
    logic [ID_BITS-1:0] top_id;
    logic               stk_nonempty;
    logic               rd_valid;
    logic [ID_BITS-1:0] fresh_id;
    logic               exhausted;
    logic [ID_BITS-1:0] grant_id;
    logic [ID_BITS-1:0] wr_id;
    status_t            status_next;
    logic               grant_ok;

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign can_load = !out_valid_reg || m_tready;
    assign load     = (state_reg == S_EXEC) && can_load;

    assign hid_wide     = WIDE'(s_tdata[HID_W-1:0]);
    assign hid_in_range = ((hid_wide >> ID_BITS) == '0);
    assign hid_id       = hid_wide[ID_BITS-1:0];

    always_comb begin
        stk_ctrl        = '0;
        vmap_ctrl       = '0;
        stk_ctrl.rd_en  = accept;
        vmap_ctrl.rd_en = accept;
        grant_id        = '0;
        grant_ok        = 1'b0;
        wr_id           = id_reg;
        status_next     = ST_OK;
        if (op_reg == OP_ALLOC) begin
            if (stk_nonempty) begin
                grant_id     = top_id;
                grant_ok     = 1'b1;
                stk_ctrl.pop = load;
            end else if (!exhausted) begin
                grant_id       = fresh_id;
                grant_ok       = 1'b1;
                vmap_ctrl.bump = load;
            end else begin
                status_next = ST_EXHAUSTED;
            end
            wr_id            = grant_id;
            vmap_ctrl.wr_en  = load && grant_ok;
            vmap_ctrl.wr_val = 1'b1;
        end else begin
            if (ofs_nz_reg) begin
                status_next = ST_BAD_OFFSET;
            end else if (!in_range_reg || !rd_valid) begin
                status_next = ST_NOT_ALLOCATED;
            end else begin
                vmap_ctrl.wr_en = load;
                stk_ctrl.push   = load;
            end
            vmap_ctrl.wr_val = 1'b0;
        end
    end

    assign serial_next = serial_reg + {{(SER_W-1){1'b0}}, 1'b1};

    hip_free_stack #(.ID_BITS(ID_BITS)) u_stack (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (stk_ctrl),
        .push_id  (id_reg),
        .top_id   (top_id),
        .nonempty (stk_nonempty)
    );

    hip_valid_map #(.ID_BITS(ID_BITS)) u_vmap (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (vmap_ctrl),
        .rd_id     (hid_id),
        .wr_id     (wr_id),
        .rd_valid  (rd_valid),
        .fresh_id  (fresh_id),
        .exhausted (exhausted)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            serial_reg    <= '0;
        end else begin
            case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        state_reg <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (load) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
            if (load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            if (load && grant_ok) begin
                serial_reg <= serial_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg       <= s_tuser;
            in_range_reg <= hid_in_range;
            ofs_nz_reg   <= (s_tdata[HID_W+OFS_W-1:HID_W] != '0);
            id_reg       <= hid_id;
        end
        if (load) begin
            out_id_reg     <= grant_ok ? HID_W'(grant_id) : '0;
            out_serial_reg <= grant_ok ? serial_next : '0;
            out_status_reg <= status_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_DATA_W-HID_W-SER_W-ST_W){1'b0}}, out_status_reg,
                       out_serial_reg, out_id_reg};

    a_accept_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (state_reg == S_EXEC))
        else $error("Accepted transaction did not move to the decide cycle.");

    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> $past(state_reg == S_EXEC))
        else $error("Result appeared without a decide cycle.");

    a_serial_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (load && grant_ok) |=> (serial_reg == $past(serial_reg) + 1'b1
                                && out_serial_reg == serial_reg))
        else $error("Serial counter and granted serial disagree.");

endmodule

// ===== design/hip_free_stack.sv =====
// Stack of freed IDs held in a synchronous memory, with its depth counter.
module hip_free_stack
    import hip_pkg::*;
#(
    parameter int ID_BITS = 10
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  stk_ctrl_t          ctrl,
    input  logic [ID_BITS-1:0] push_id,
    output logic [ID_BITS-1:0] top_id,
    output logic               nonempty
);

    localparam int DEPTH = 1 << ID_BITS;

    logic [ID_BITS-1:0] mem [DEPTH];
    logic [ID_BITS:0]   depth_reg;
    logic [ID_BITS:0]   depth_next;
    logic [ID_BITS:0]   depth_dec;
    logic [ID_BITS-1:0] top_reg;

    assign depth_dec = depth_reg - {{ID_BITS{1'b0}}, 1'b1};

    always_comb begin
        depth_next = depth_reg;
        if (ctrl.pop) begin
            depth_next = depth_dec;
        end else if (ctrl.push) begin
            depth_next = depth_reg + {{ID_BITS{1'b0}}, 1'b1};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            depth_reg <= '0;
        end else begin
            depth_reg <= depth_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.push) begin
            mem[depth_reg[ID_BITS-1:0]] <= push_id;
        end
        if (ctrl.rd_en) begin
            top_reg <= mem[depth_dec[ID_BITS-1:0]];
        end
    end

    assign top_id   = top_reg;
    assign nonempty = (depth_reg != '0);

    a_push_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctrl.push && !ctrl.pop) |=> (depth_reg == $past(depth_reg) + 1'b1))
        else $error("Stack depth did not grow after a push.");

endmodule

// ===== design/hip_valid_map.sv =====
// Valid bit per ID in a synchronous memory, qualified by the high-water mark.
module hip_valid_map
    import hip_pkg::*;
#(
    parameter int ID_BITS = 10
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  vmap_ctrl_t         ctrl,
    input  logic [ID_BITS-1:0] rd_id,
    input  logic [ID_BITS-1:0] wr_id,
    output logic               rd_valid,
    output logic [ID_BITS-1:0] fresh_id,
    output logic               exhausted
);

    localparam int DEPTH = 1 << ID_BITS;

    logic               mem [DEPTH];
    logic [ID_BITS-1:0] highest_reg;
    logic               bit_reg;
    logic               gate_reg;

    // Entries above the high-water mark, and ID zero, were never written since reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            highest_reg <= '0;
        end else if (ctrl.bump) begin
            highest_reg <= fresh_id;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.wr_en) begin
            mem[wr_id] <= ctrl.wr_val;
        end
        if (ctrl.rd_en) begin
            bit_reg  <= mem[rd_id];
            gate_reg <= (rd_id != '0) && (rd_id <= highest_reg);
        end
    end

    assign fresh_id  = highest_reg + {{(ID_BITS-1){1'b0}}, 1'b1};
    assign exhausted = (highest_reg == {ID_BITS{1'b1}});
    assign rd_valid  = bit_reg && gate_reg;

endmodule

// ===== sim/tb_handle_id_pool.sv =====
// Self-checking testbench for the handle ID pool with a built-in allocation predictor.
module tb_handle_id_pool;
    import hip_pkg::*;

    localparam int ID_LAST        = (1 << HID_W) - 1;
    localparam int MAX_IDLE       = 8;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES   = 8;
    localparam int PAD_W          = S_DATA_W - HID_W - OFS_W;

    typedef struct {
        logic [HID_W-1:0] gid;
        logic [SER_W-1:0] ser;
        status_t          st;
    } grant_t;

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata  = '0;
    logic                s_tuser  = 1'b0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;

    // Predicted pool state.
    logic [HID_W-1:0] freed_ids[$];
    bit               id_live[0:ID_LAST];
    int               top_issued = 0;
    logic [SER_W-1:0] serial_cnt = '0;

    grant_t expected_q[$];

    bit tx_steady = 1'b0;
    bit rx_steady = 1'b0;
    bit hold_rx   = 1'b0;

    int errors      = 0;
    int quiet_count = 0;
    int n_alloc_req = 0;
    int n_free_req  = 0;
    int status_seen[4];

    handle_id_pool #(
        .ID_BITS(HID_W)
    ) i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    always #4 aclk = ~aclk;

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_count <= 0;
        end else begin
            quiet_count <= quiet_count + 1;
        end
        if (quiet_count >= WATCHDOG_LIMIT) begin
            $display("Timeout: no transaction for %0d cycles, %0d results outstanding.",
                     quiet_count, expected_q.size());
            $display("handle_id_pool verification failed");
            $finish;
        end
    end

    function automatic grant_t pool_result(op_t op, logic [HID_W-1:0] hid,
                                           logic [OFS_W-1:0] ofs);
        grant_t           r;
        logic [HID_W-1:0] id;
        r.gid = '0;
        r.ser = '0;
        r.st  = ST_OK;
        if (op == OP_ALLOC) begin
            if (freed_ids.size() > 0) begin
                id = freed_ids[freed_ids.size() - 1];
                freed_ids.delete(freed_ids.size() - 1);
            end else if (top_issued >= ID_LAST) begin
                r.st = ST_EXHAUSTED;
                return r;
            end else begin
                top_issued++;
                id = top_issued[HID_W-1:0];
            end
            id_live[id] = 1'b1;
            serial_cnt  = serial_cnt + 1'b1;
            r.gid       = id;
            r.ser       = serial_cnt;
        end else if (ofs != '0) begin
            r.st = ST_BAD_OFFSET;
        end else if (!id_live[hid]) begin
            r.st = ST_NOT_ALLOCATED;
        end else begin
            id_live[hid] = 1'b0;
            freed_ids.insert(freed_ids.size(), hid);
        end
        return r;
    endfunction

    task automatic send_req(op_t op, logic [HID_W-1:0] hid, logic [OFS_W-1:0] ofs);
        int     gap;
        grant_t r;
        gap = tx_steady ? 0 : $urandom_range(0, MAX_IDLE);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {{PAD_W{1'b0}}, ofs, hid};
        do @(posedge aclk); while (s_tready !== 1'b1);
        r = pool_result(op, hid, ofs);
        expected_q.insert(expected_q.size(), r);
        status_seen[r.st]++;
        if (op == OP_ALLOC) begin
            n_alloc_req++;
        end else begin
            n_free_req++;
        end
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (expected_q.size() != 0) @(posedge aclk);
    endtask

    // Returns 0 when no live ID was found after a few tries.
    function automatic int pick_live_id();
        int id;
        if (top_issued == 0) begin
            return 0;
        end
        for (int i = 0; i < 16; i++) begin
            id = $urandom_range(1, top_issued);
            if (id_live[id]) begin
                return id;
            end
        end
        return 0;
    endfunction

    task automatic test_directed();
        send_req(OP_FREE, '0, '0);
        send_req(OP_ALLOC, '0, '0);
        send_req(OP_ALLOC, '0, '0);
        send_req(OP_ALLOC, '0, '0);
        send_req(OP_FREE, HID_W'(2), 32'h0000_0001);
        send_req(OP_FREE, HID_W'(2), 32'hFFFF_FFFF);
        send_req(OP_FREE, HID_W'(ID_LAST), '0);
        send_req(OP_FREE, HID_W'(ID_LAST), 32'h8000_0000);
        send_req(OP_FREE, HID_W'(2), '0);
        send_req(OP_FREE, HID_W'(2), '0);
        send_req(OP_FREE, HID_W'(3), '0);
        send_req(OP_ALLOC, '0, '0);
        send_req(OP_ALLOC, '0, '0);
        send_req(OP_ALLOC, HID_W'(ID_LAST), 32'hFFFF_FFFF);
        send_req(OP_FREE, HID_W'(1), '0);
        send_req(OP_FREE, '0, 32'h0000_0000);
        send_req(OP_ALLOC, '0, '0);
        wait_idle();
    endtask

    task automatic test_mixed(int count);
        int               sel;
        int               id;
        logic [OFS_W-1:0] ofs;
        for (int n = 0; n < count; n++) begin
            if (n % 50 == 0) begin
                tx_steady = ($urandom_range(0, 3) == 0);
                rx_steady = ($urandom_range(0, 3) == 0);
            end
            sel = $urandom_range(0, 99);
            if (sel < 45) begin
                send_req(OP_ALLOC, HID_W'($urandom), $urandom);
            end else if (sel < 85) begin
                id = pick_live_id();
                if (id != 0) begin
                    send_req(OP_FREE, HID_W'(id), '0);
                end else begin
                    send_req(OP_ALLOC, HID_W'($urandom), $urandom);
                end
            end else if (sel < 93) begin
                ofs = $urandom;
                if (ofs == '0) begin
                    ofs = 1 << $urandom_range(0, OFS_W - 1);
                end
                send_req(OP_FREE, HID_W'($urandom), ofs);
            end else begin
                send_req(OP_FREE, HID_W'($urandom_range(0, ID_LAST)), '0);
            end
        end
        tx_steady = 1'b0;
        rx_steady = 1'b0;
    endtask

    task automatic test_backpressure();
        int id;
        hold_rx   = 1'b1;
        tx_steady = 1'b1;
        for (int n = 0; n < 24; n++) begin
            id = pick_live_id();
            if (n % 3 == 2 && id != 0) begin
                send_req(OP_FREE, HID_W'(id), '0);
            end else begin
                send_req(OP_ALLOC, '0, '0);
            end
        end
        tx_steady = 1'b0;
        wait_idle();
    endtask

    task automatic test_exhaustion();
        int n;
        n = 0;
        while (freed_ids.size() > 0 || top_issued < ID_LAST) begin
            if (n % 100 == 0) begin
                tx_steady = ($urandom_range(0, 2) == 0);
                rx_steady = ($urandom_range(0, 2) == 0);
            end
            send_req(OP_ALLOC, HID_W'($urandom), $urandom);
            n++;
        end
        tx_steady = 1'b0;
        rx_steady = 1'b0;
        send_req(OP_ALLOC, '0, '0);
        send_req(OP_ALLOC, HID_W'(ID_LAST), 32'hFFFF_FFFF);
        send_req(OP_FREE, HID_W'(ID_LAST), '0);
        send_req(OP_ALLOC, '0, '0);
        send_req(OP_ALLOC, '0, '0);
        wait_idle();
    endtask

    // Result sink: random stalls, an occasional long hold-off, and the field checks.
    initial begin : result_sink
        int     stall;
        grant_t got;
        grant_t want;
        do @(posedge aclk); while (aresetn !== 1'b1);
        forever begin
            if (hold_rx) begin
                hold_rx = 1'b0;
                stall   = HOLD_CYCLES;
            end else if (rx_steady) begin
                stall = 0;
            end else begin
                stall = $urandom_range(0, MAX_IDLE);
            end
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (m_tvalid !== 1'b1);
            got.gid = m_tdata[HID_W-1:0];
            got.ser = m_tdata[HID_W+SER_W-1:HID_W];
            got.st  = status_t'(m_tdata[HID_W+SER_W+ST_W-1:HID_W+SER_W]);
            if (expected_q.size() == 0) begin
                errors++;
                if (errors <= 10) begin
                    $display("Unexpected transaction: id %0d serial %0d status %0d",
                             got.gid, got.ser, got.st);
                end
            end else begin
                want = expected_q.pop_front();
                if (got.gid !== want.gid || got.ser !== want.ser || got.st !== want.st) begin
                    errors++;
                    if (errors <= 10) begin
                        $display("Mismatch: expected id %0d serial %0d status %0d,",
                                 want.gid, want.ser, want.st);
                        $display("          got id %0d serial %0d status %0d",
                                 got.gid, got.ser, got.st);
                    end
                end
            end
        end
    end

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_mixed(100);
        test_backpressure();
        test_exhaustion();
        test_mixed(120);

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Sent %0d requests: %0d allocate, %0d free; highest fresh ID %0d.",
                 n_alloc_req + n_free_req, n_alloc_req, n_free_req, top_issued);
        $display("Outcomes: ok %0d, exhausted %0d, bad offset %0d, not allocated %0d.",
                 status_seen[ST_OK], status_seen[ST_EXHAUSTED],
                 status_seen[ST_BAD_OFFSET], status_seen[ST_NOT_ALLOCATED]);
        if (errors == 0 && expected_q.size() == 0) begin
            $display("handle_id_pool verification clean");
        end else begin
            $display("%0d errors, %0d results never arrived.", errors, expected_q.size());
            $display("handle_id_pool verification failed");
        end
        $finish;
    end

endmodule

// ===== handle_id_pool.f =====
design/hip_pkg.sv
design/hip_free_stack.sv
design/hip_valid_map.sv
design/handle_id_pool.sv
sim/tb_handle_id_pool.sv
